// ===== rtl/core/ptc_pkg.sv =====
package ptc_pkg;

  localparam int V_W    = 19;  // probe voltage, 0.01 mV units
  localparam int PH_W   = 16;  // milli-pH
  localparam int ST_W   = 3;
  localparam int OP_W   = 3;
  localparam int DIFF_W = V_W + 1;      // signed voltage difference
  localparam int PROD_W = 34;           // signed numerator and products
  localparam int NUM_W  = PROD_W - 1;   // numerator magnitude
  localparam int CNT_W  = 6;            // holds NUM_W - 1

  localparam logic [OP_W-1:0] OP_READ        = 3'd0;
  localparam logic [OP_W-1:0] OP_ENTER       = 3'd1;
  localparam logic [OP_W-1:0] OP_CAP_NEUTRAL = 3'd2;
  localparam logic [OP_W-1:0] OP_CAP_ACID    = 3'd3;
  localparam logic [OP_W-1:0] OP_EXIT        = 3'd4;

  localparam logic [ST_W-1:0] ST_FAIL       = 3'd0;
  localparam logic [ST_W-1:0] ST_OK         = 3'd1;
  localparam logic [ST_W-1:0] ST_CAPTURED   = 3'd2;
  localparam logic [ST_W-1:0] ST_UNKNOWN    = 3'd3;
  localparam logic [ST_W-1:0] ST_DEGENERATE = 3'd4;

  localparam logic [V_W-1:0] NEUTRAL_RESET = 19'd150000;
  localparam logic [V_W-1:0] ACID_RESET    = 19'd203244;

  localparam logic signed [PH_W-1:0] PH_RESET   = 16'sd7000;
  localparam logic signed [PH_W-1:0] PH_N_LO    = 16'sd6600;
  localparam logic signed [PH_W-1:0] PH_N_HI    = 16'sd7400;
  localparam logic signed [PH_W-1:0] PH_A_LO    = 16'sd3600;
  localparam logic signed [PH_W-1:0] PH_A_HI    = 16'sd4400;
  localparam logic signed [PH_W-1:0] PH_SAT_MAX = 16'sd32767;
  localparam logic signed [PH_W-1:0] PH_SAT_MIN = -16'sd32768;

  // slope 3 pH per span and offset 7 pH, in milli-pH
  localparam logic signed [PROD_W-1:0] K_SLOPE  = 34'sd3000;
  localparam logic signed [PROD_W-1:0] K_OFFSET = 34'sd7000;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [V_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/ptc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module ptc_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  ptc_pkg::div_req_t   req,
  output ptc_pkg::div_rsp_t   rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic [ptc_pkg::CNT_W-1:0]        cnt_r;
  logic [ptc_pkg::NUM_W-1:0]        quo_r;
  logic [ptc_pkg::V_W-1:0]          rem_r;
  logic [ptc_pkg::V_W-1:0]          den_r;
  logic [ptc_pkg::V_W:0]            rem_sh;
  logic                             ge;
  logic [ptc_pkg::V_W:0]            rem_nxt;

  assign rem_sh  = {rem_r, quo_r[ptc_pkg::NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt[ptc_pkg::V_W-1:0];
        quo_r <= {quo_r[ptc_pkg::NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ptc_pkg::CNT_W'(ptc_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== rtl/core/ph_two_point_calibrator.sv =====
// Read pH, from accepted transaction to out_valid: products, sum and divider load,
// one divider iteration per numerator bit, saturation, output load. Other ops:
// output load only. One transaction at a time: in_stall stays high from acceptance
// until the result enters the output register, so a stalled output also stalls input.
// Synchronous active-low reset: calibration points and last pH to defaults,
// session flags cleared, output register empty.
module ph_two_point_calibrator (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptc_pkg::OP_W-1:0]      in_op,
  input  logic [ptc_pkg::V_W-1:0]       in_voltage,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ptc_pkg::PH_W-1:0] out_ph_value,
  output logic [ptc_pkg::ST_W-1:0]      out_status,
  output logic                          out_store_neutral,
  output logic                          out_store_acid,
  output logic [ptc_pkg::V_W-1:0]       out_stored_voltage
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a transaction
    S_MUL,    // slope and offset products
    S_SUM,    // numerator, magnitudes, divider start
    S_DIV,    // waiting on the divider
    S_DONE    // result ready, waiting for the output register
  } state_t;

  state_t state_r;

  // calibration state
  logic [ptc_pkg::V_W-1:0]           neutral_r;
  logic [ptc_pkg::V_W-1:0]           acid_r;
  logic                              in_cal_r;
  logic                              taken_r;
  logic signed [ptc_pkg::PH_W-1:0]   last_ph_r;

  // read datapath
  logic [ptc_pkg::V_W-1:0]           v_r;
  logic signed [ptc_pkg::PROD_W-1:0] p_slope_r;
  logic signed [ptc_pkg::PROD_W-1:0] p_off_r;
  logic                              neg_r;

  // pending result
  logic signed [ptc_pkg::PH_W-1:0]   res_ph_r;
  logic [ptc_pkg::ST_W-1:0]          res_st_r;
  logic                              res_sn_r;
  logic                              res_sa_r;
  logic [ptc_pkg::V_W-1:0]           res_sv_r;

  // output register
  logic                              out_valid_r;
  logic signed [ptc_pkg::PH_W-1:0]   out_ph_r;
  logic [ptc_pkg::ST_W-1:0]          out_st_r;
  logic                              out_sn_r;
  logic                              out_sa_r;
  logic [ptc_pkg::V_W-1:0]           out_sv_r;

  logic                              accept;
  logic                              out_free;
  logic                              out_load;
  logic signed [ptc_pkg::DIFF_W-1:0] dv;   // v - n
  logic signed [ptc_pkg::DIFF_W-1:0] dn;   // n - a
  logic signed [ptc_pkg::PROD_W-1:0] num;
  logic [ptc_pkg::NUM_W-1:0]         num_mag;
  logic [ptc_pkg::V_W-1:0]           den_mag;
  logic [ptc_pkg::NUM_W-1:0]         q_mag;
  logic signed [ptc_pkg::PH_W-1:0]   ph_sat;
  logic                              win_n;
  logic                              win_a;

  // op decode of the offered transaction
  logic [ptc_pkg::ST_W-1:0]          dec_st;
  logic                              dec_sn;
  logic                              dec_sa;
  logic [ptc_pkg::V_W-1:0]           dec_sv;
  logic                              dec_read;   // read that goes through the divider

  ptc_pkg::div_req_t div_req;
  ptc_pkg::div_rsp_t div_rsp;

  ptc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && out_free;

  assign dv = $signed({1'b0, v_r}) - $signed({1'b0, neutral_r});
  assign dn = $signed({1'b0, neutral_r}) - $signed({1'b0, acid_r});

  // pH*1000 = (3000*(v-n) + 7000*(n-a)) / (n-a); divide magnitudes, sign after
  assign num     = p_slope_r + p_off_r;
  assign num_mag = num[ptc_pkg::PROD_W-1] ? ptc_pkg::NUM_W'(-num)
                                          : num[ptc_pkg::NUM_W-1:0];
  assign den_mag = dn[ptc_pkg::DIFF_W-1] ? ptc_pkg::V_W'(-dn)
                                         : dn[ptc_pkg::V_W-1:0];

  assign div_req.start = (state_r == S_SUM);
  assign div_req.num   = num_mag;
  assign div_req.den   = den_mag;

  // truncation toward zero falls out of the magnitude divide; clamp to 16 bits
  assign q_mag = div_rsp.quot;
  always_comb begin
    if (neg_r) begin
      if (q_mag > ptc_pkg::NUM_W'(32768)) ph_sat = ptc_pkg::PH_SAT_MIN;
      else                                ph_sat = $signed(~q_mag[15:0] + 16'd1);
    end else begin
      if (q_mag > ptc_pkg::NUM_W'(32767)) ph_sat = ptc_pkg::PH_SAT_MAX;
      else                                ph_sat = $signed(q_mag[15:0]);
    end
  end

  // exit windows, tested on the stale last pH
  assign win_n = (last_ph_r > ptc_pkg::PH_N_LO) && (last_ph_r < ptc_pkg::PH_N_HI);
  assign win_a = (last_ph_r > ptc_pkg::PH_A_LO) && (last_ph_r < ptc_pkg::PH_A_HI);

  // result fields for the op on the input; read pH is filled in after the divide
  always_comb begin
    dec_st   = ptc_pkg::ST_UNKNOWN;
    dec_sn   = 1'b0;
    dec_sa   = 1'b0;
    dec_sv   = '0;
    dec_read = 1'b0;
    unique case (in_op) inside
      ptc_pkg::OP_READ: begin
        if (neutral_r == acid_r) begin
          dec_st = ptc_pkg::ST_DEGENERATE;   // flat line, keep last pH
        end else begin
          dec_st   = ptc_pkg::ST_OK;
          dec_read = 1'b1;
        end
      end
      ptc_pkg::OP_ENTER: begin
        dec_st = ptc_pkg::ST_OK;
      end
      ptc_pkg::OP_CAP_NEUTRAL, ptc_pkg::OP_CAP_ACID: begin
        if (in_cal_r) begin
          dec_sn = (in_op == ptc_pkg::OP_CAP_NEUTRAL);
          dec_sa = (in_op == ptc_pkg::OP_CAP_ACID);
          dec_sv = in_voltage;
          dec_st = ptc_pkg::ST_CAPTURED;
        end else begin
          dec_st = ptc_pkg::ST_OK;
        end
      end
      ptc_pkg::OP_EXIT: begin
        dec_st = ptc_pkg::ST_FAIL;
        if (in_cal_r && taken_r) begin
          if (win_n) begin
            dec_sn = 1'b1;
            dec_sv = neutral_r;
            dec_st = ptc_pkg::ST_OK;
          end else if (win_a) begin
            dec_sa = 1'b1;
            dec_sv = acid_r;
            dec_st = ptc_pkg::ST_OK;
          end
        end
      end
      default: dec_st = ptc_pkg::ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      neutral_r   <= ptc_pkg::NEUTRAL_RESET;
      acid_r      <= ptc_pkg::ACID_RESET;
      in_cal_r    <= 1'b0;
      taken_r     <= 1'b0;
      last_ph_r   <= ptc_pkg::PH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_ph_r <= last_ph_r;
            res_st_r <= dec_st;
            res_sn_r <= dec_sn;
            res_sa_r <= dec_sa;
            res_sv_r <= dec_sv;
            v_r      <= in_voltage;
            state_r  <= dec_read ? S_MUL : S_DONE;
            if (in_op == ptc_pkg::OP_ENTER) begin
              in_cal_r <= 1'b1;
              taken_r  <= 1'b0;
            end else if (dec_st == ptc_pkg::ST_CAPTURED) begin
              taken_r <= 1'b1;
              if (dec_sn) neutral_r <= in_voltage;
              else        acid_r    <= in_voltage;
            end else if (in_op == ptc_pkg::OP_EXIT && in_cal_r && taken_r) begin
              in_cal_r <= 1'b0;
              taken_r  <= 1'b0;
            end
          end
        end
        S_MUL: begin
          p_slope_r <= ptc_pkg::PROD_W'(dv) * ptc_pkg::K_SLOPE;
          p_off_r   <= ptc_pkg::PROD_W'(dn) * ptc_pkg::K_OFFSET;
          state_r   <= S_SUM;
        end
        S_SUM: begin
          neg_r   <= num[ptc_pkg::PROD_W-1] ^ dn[ptc_pkg::DIFF_W-1];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            last_ph_r <= ph_sat;
            res_ph_r  <= ph_sat;
            res_st_r  <= ptc_pkg::ST_OK;
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_ph_r <= res_ph_r;
            out_st_r <= res_st_r;
            out_sn_r <= res_sn_r;
            out_sa_r <= res_sa_r;
            out_sv_r <= res_sv_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ph_value       = out_ph_r;
  assign out_status         = out_st_r;
  assign out_store_neutral  = out_sn_r;
  assign out_store_acid     = out_sa_r;
  assign out_stored_voltage = out_sv_r;

  // a finished quotient only arrives while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide wait");

  // a session flag pair: no point can be taken outside a session
  a_taken_in_session: assert property (@(posedge clk) disable iff (!rst_n)
    !in_cal_r |-> !taken_r)
    else $error("point taken with no open session");

  // a transaction always moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted transaction left sequencer idle");

  // never both store requests on one result
  a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_sn_r && out_sa_r))
    else $error("both store requests raised");

  // a capture raises exactly one store request
  a_capture_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == ptc_pkg::ST_CAPTURED)) |-> (out_sn_r ^ out_sa_r))
    else $error("capture without a single store request");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // op codes the block does not decode; all three must answer "unknown"
  localparam logic [ptc_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [ptc_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [ptc_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int V_MAX = (1 << ptc_pkg::V_W) - 1;
  localparam int DRAIN_CYCLES = 60;   // margin beyond the read latency

  // one result transaction as seen on the out_ channel
  typedef struct packed {
    logic signed [ptc_pkg::PH_W-1:0] ph;
    logic [ptc_pkg::ST_W-1:0]        status;
    logic                            sn;
    logic                            sa;
    logic [ptc_pkg::V_W-1:0]         sv;
  } ph_result_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    logic [ptc_pkg::OP_W-1:0] op;
    logic [ptc_pkg::V_W-1:0]  v;
    logic                     typed;
    ph_result_t               given;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [ptc_pkg::OP_W-1:0]        in_op = '0;
  logic [ptc_pkg::V_W-1:0]         in_voltage = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [ptc_pkg::PH_W-1:0] out_ph_value;
  logic [ptc_pkg::ST_W-1:0]        out_status;
  logic                            out_store_neutral;
  logic                            out_store_acid;
  logic [ptc_pkg::V_W-1:0]         out_stored_voltage;

  ph_two_point_calibrator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_voltage         (in_voltage),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ph_value       (out_ph_value),
    .out_status         (out_status),
    .out_store_neutral  (out_store_neutral),
    .out_store_acid     (out_store_acid),
    .out_stored_voltage (out_stored_voltage)
  );

  always #10 clk = ~clk;

  // Predictor state: mirrors the calibration registers of the block.
  logic [ptc_pkg::V_W-1:0]         cal_neutral;
  logic [ptc_pkg::V_W-1:0]         cal_acid;
  logic                            session_open;
  logic                            point_held;
  logic signed [ptc_pkg::PH_W-1:0] last_mph;

  ph_result_t pending_results[$];   // results owed by the block, oldest first
  stim_row_t  directed_rows[$];
  int         errors = 0;
  int         sent = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;

  // pH on the line through (neutral, 7000) and (acid, 4000), milli-pH,
  // truncated toward zero, then clamped to the 16-bit range.
  function automatic logic signed [ptc_pkg::PH_W-1:0] line_fit_mph(
      input logic [ptc_pkg::V_W-1:0] v,
      input logic [ptc_pkg::V_W-1:0] n,
      input logic [ptc_pkg::V_W-1:0] a);
    longint den;
    longint num;
    longint q;
    den = longint'(n) - longint'(a);
    num = longint'(ptc_pkg::K_SLOPE) * (longint'(v) - longint'(n))
        + longint'(ptc_pkg::K_OFFSET) * den;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    q = num / den;
    if (q > longint'(ptc_pkg::PH_SAT_MAX)) q = longint'(ptc_pkg::PH_SAT_MAX);
    if (q < longint'(ptc_pkg::PH_SAT_MIN)) q = longint'(ptc_pkg::PH_SAT_MIN);
    return q[ptc_pkg::PH_W-1:0];
  endfunction

  // Advances the predictor by one accepted transaction and returns its result.
  function automatic ph_result_t calibrate_step(input logic [ptc_pkg::OP_W-1:0] op,
                                                input logic [ptc_pkg::V_W-1:0] v);
    ph_result_t r;
    r = '0;
    case (op)
      ptc_pkg::OP_READ: begin
        if (cal_neutral == cal_acid) begin
          r.status = ptc_pkg::ST_DEGENERATE;   // flat line, keep last pH
        end else begin
          last_mph = line_fit_mph(v, cal_neutral, cal_acid);
          r.status = ptc_pkg::ST_OK;
        end
      end
      ptc_pkg::OP_ENTER: begin
        session_open = 1'b1;
        point_held = 1'b0;
        r.status = ptc_pkg::ST_OK;
      end
      ptc_pkg::OP_CAP_NEUTRAL, ptc_pkg::OP_CAP_ACID: begin
        if (session_open) begin
          if (op == ptc_pkg::OP_CAP_NEUTRAL) begin
            cal_neutral = v;
            r.sn = 1'b1;
          end else begin
            cal_acid = v;
            r.sa = 1'b1;
          end
          r.sv = v;
          point_held = 1'b1;
          r.status = ptc_pkg::ST_CAPTURED;
        end else begin
          r.status = ptc_pkg::ST_OK;
        end
      end
      ptc_pkg::OP_EXIT: begin
        r.status = ptc_pkg::ST_FAIL;
        if (session_open && point_held) begin
          // stale pH: whatever the last read left behind
          if (last_mph > ptc_pkg::PH_N_LO && last_mph < ptc_pkg::PH_N_HI) begin
            r.sn = 1'b1;
            r.sv = cal_neutral;
            r.status = ptc_pkg::ST_OK;
          end else if (last_mph > ptc_pkg::PH_A_LO && last_mph < ptc_pkg::PH_A_HI) begin
            r.sa = 1'b1;
            r.sv = cal_acid;
            r.status = ptc_pkg::ST_OK;
          end
          session_open = 1'b0;
          point_held = 1'b0;
        end
      end
      default: r.status = ptc_pkg::ST_UNKNOWN;
    endcase
    r.ph = last_mph;
    return r;
  endfunction

  function automatic logic [ptc_pkg::V_W-1:0] rand_v();
    return ptc_pkg::V_W'($urandom_range(0, V_MAX));
  endfunction

  function automatic logic [ptc_pkg::OP_W-1:0] rand_op();
    return ptc_pkg::OP_W'($urandom_range(0, 7));
  endfunction

  // Drives one transaction. Entered and left just after a falling edge, so
  // in_valid gets a single nonblocking update per time step.
  task automatic send_item(input logic [ptc_pkg::OP_W-1:0] op,
                           input logic [ptc_pkg::V_W-1:0] v,
                           input logic typed, input ph_result_t given);
    ph_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_voltage <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    r = calibrate_step(op, v);
    pending_results.push_back(typed ? given : r);
    sent++;
    @(negedge clk);
  endtask

  task automatic send(input logic [ptc_pkg::OP_W-1:0] op,
                      input logic [ptc_pkg::V_W-1:0] v);
    send_item(op, v, 1'b0, '0);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic [ptc_pkg::OP_W-1:0] op, input int v,
                         input logic typed, input int ph,
                         input logic [ptc_pkg::ST_W-1:0] st,
                         input logic sn, input logic sa, input int sv);
    stim_row_t row;
    row.op = op;
    row.v = ptc_pkg::V_W'(v);
    row.typed = typed;
    row.given.ph = ptc_pkg::PH_W'(ph);
    row.given.status = st;
    row.given.sn = sn;
    row.given.sa = sa;
    row.given.sv = ptc_pkg::V_W'(sv);
    directed_rows.push_back(row);
  endtask

  // row checked against the predictor
  task automatic add_free(input logic [ptc_pkg::OP_W-1:0] op, input int v);
    add_row(op, v, 1'b0, 0, ptc_pkg::ST_FAIL, 1'b0, 1'b0, 0);
  endtask

  // a voltage within +-10 mV of a calibration point, clamped to the field
  function automatic logic [ptc_pkg::V_W-1:0] near_point(input int base);
    int x;
    x = base + int'($urandom_range(0, 2000)) - 1000;
    if (x < 0) x = 0;
    if (x > V_MAX) x = V_MAX;
    return ptc_pkg::V_W'(x);
  endfunction

  // Well-formed calibration session with random content: enter, capture one
  // or both points, a few reads near the points, exit. Some sessions are
  // broken on purpose (early exit, stray ops, equal or reversed points).
  task automatic calibration_session();
    int vn;
    int va;
    int sel;
    vn = int'($urandom_range(60000, 250000));
    sel = int'($urandom_range(99));
    if (sel < 70) va = vn + int'($urandom_range(20000, 80000));
    else if (sel < 85) va = vn - int'($urandom_range(20000, 50000));
    else if (sel < 93) va = int'($urandom_range(0, V_MAX));
    else va = vn;                                // degenerate line
    send(ptc_pkg::OP_ENTER, rand_v());
    if ($urandom_range(99) < 10) send(ptc_pkg::OP_EXIT, rand_v());
    if ($urandom_range(1)) begin
      send(ptc_pkg::OP_CAP_NEUTRAL, ptc_pkg::V_W'(vn));
      if ($urandom_range(99) < 80) send(ptc_pkg::OP_CAP_ACID, ptc_pkg::V_W'(va));
    end else begin
      send(ptc_pkg::OP_CAP_ACID, ptc_pkg::V_W'(va));
      if ($urandom_range(99) < 80) send(ptc_pkg::OP_CAP_NEUTRAL, ptc_pkg::V_W'(vn));
    end
    repeat ($urandom_range(0, 3))
      send(ptc_pkg::OP_READ, near_point($urandom_range(1) ? vn : va));
    if ($urandom_range(99) < 10) send(rand_op(), rand_v());
    send(ptc_pkg::OP_EXIT, rand_v());
  endtask

  task automatic random_phase(input int n, input int tx_pct, input int rx_pct);
    int target;
    int sel;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = sent + n;
    while (sent < target) begin
      sel = int'($urandom_range(99));
      if (sel < 60) calibration_session();
      else if (sel < 85) send(ptc_pkg::OP_READ, rand_v());
      else send(rand_op(), rand_v());
      if ($urandom_range(199) == 0) drain();
    end
    drain();
  endtask

  // Receiver: random stall, re-rolled at every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    ph_result_t e;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t result expected none actual ph_value %0d status %0d", $time,
                 out_ph_value, out_status);
      end else begin
        e = pending_results.pop_front();
        if (out_ph_value !== e.ph) begin
          errors++;
          $display("%0t ph_value expected %0d actual %0d", $time, $signed(e.ph),
                   out_ph_value);
        end
        if (out_status !== e.status) begin
          errors++;
          $display("%0t status expected %0d actual %0d", $time, e.status, out_status);
        end
        if (out_store_neutral !== e.sn) begin
          errors++;
          $display("%0t store_neutral expected %0d actual %0d", $time, e.sn,
                   out_store_neutral);
        end
        if (out_store_acid !== e.sa) begin
          errors++;
          $display("%0t store_acid expected %0d actual %0d", $time, e.sa, out_store_acid);
        end
        if (out_stored_voltage !== e.sv) begin
          errors++;
          $display("%0t stored_voltage expected %0d actual %0d", $time, e.sv,
                   out_stored_voltage);
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("ph_two_point_calibrator verification failed");
    $finish;
  end

  initial begin : stimulus
    // predictor starts from the reset values
    cal_neutral  = ptc_pkg::NEUTRAL_RESET;
    cal_acid     = ptc_pkg::ACID_RESET;
    session_open = 1'b0;
    point_held   = 1'b0;
    last_mph     = ptc_pkg::PH_RESET;

    // Directed table. Typed rows: results obvious from reset values,
    // the exact points, saturation and status codes.
    add_row(ptc_pkg::OP_READ, 150000, 1'b1, 4000 + 3000, ptc_pkg::ST_OK,
            1'b0, 1'b0, 0);                                    // at neutral point
    add_row(ptc_pkg::OP_READ, 203244, 1'b1, 4000, ptc_pkg::ST_OK,
            1'b0, 1'b0, 0);                                    // at acid point
    add_row(OP_SPARE_5, 0, 1'b1, 4000, ptc_pkg::ST_UNKNOWN, 1'b0, 1'b0, 0);
    add_row(OP_SPARE_6, V_MAX, 1'b1, 4000, ptc_pkg::ST_UNKNOWN, 1'b0, 1'b0, 0);
    add_row(OP_SPARE_7, 12345, 1'b1, 4000, ptc_pkg::ST_UNKNOWN, 1'b0, 1'b0, 0);
    add_row(ptc_pkg::OP_EXIT, 0, 1'b1, 4000, ptc_pkg::ST_FAIL,
            1'b0, 1'b0, 0);                                    // no session
    add_row(ptc_pkg::OP_CAP_NEUTRAL, 1000, 1'b1, 4000, ptc_pkg::ST_OK,
            1'b0, 1'b0, 0);                                    // ignored outside session
    add_row(ptc_pkg::OP_CAP_ACID, V_MAX, 1'b1, 4000, ptc_pkg::ST_OK, 1'b0, 1'b0, 0);
    add_free(ptc_pkg::OP_READ, 0);
    add_free(ptc_pkg::OP_READ, V_MAX);
    add_free(ptc_pkg::OP_ENTER, 0);
    add_free(ptc_pkg::OP_EXIT, 0);                             // nothing captured yet
    add_free(ptc_pkg::OP_CAP_ACID, 203244);
    add_row(ptc_pkg::OP_READ, 203244, 1'b1, 4000, ptc_pkg::ST_OK, 1'b0, 1'b0, 0);
    add_row(ptc_pkg::OP_EXIT, 0, 1'b1, 4000, ptc_pkg::ST_OK,
            1'b0, 1'b1, 203244);                               // acid window
    add_row(ptc_pkg::OP_ENTER, V_MAX, 1'b1, 4000, ptc_pkg::ST_OK, 1'b0, 1'b0, 0);
    add_row(ptc_pkg::OP_CAP_NEUTRAL, 150000, 1'b1, 4000, ptc_pkg::ST_CAPTURED,
            1'b1, 1'b0, 150000);
    add_free(ptc_pkg::OP_READ, 150100);
    add_free(ptc_pkg::OP_EXIT, 0);                             // neutral window
    add_free(ptc_pkg::OP_ENTER, 0);
    add_free(ptc_pkg::OP_CAP_NEUTRAL, 100000);
    add_free(ptc_pkg::OP_CAP_ACID, 100000);                    // equal points
    add_free(ptc_pkg::OP_READ, 77777);                         // degenerate read
    add_free(ptc_pkg::OP_CAP_ACID, 100001);                    // one-count span
    add_row(ptc_pkg::OP_READ, 0, 1'b1, 32767, ptc_pkg::ST_OK,
            1'b0, 1'b0, 0);                                    // clamps high
    add_row(ptc_pkg::OP_READ, V_MAX, 1'b1, -32768, ptc_pkg::ST_OK,
            1'b0, 1'b0, 0);                                    // clamps low
    add_row(ptc_pkg::OP_EXIT, 0, 1'b1, -32768, ptc_pkg::ST_FAIL,
            1'b0, 1'b0, 0);                                    // outside both windows

    tx_idle_pct = 24;
    rx_idle_pct = 67;

    // reset: held low, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].v, directed_rows[i].typed,
                directed_rows[i].given);
    end
    drain();

    random_phase(600, 24, 67);
    random_phase(600, 67, 24);
    random_phase(600, 0, 0);

    // all owed results are in; let any stray transaction surface
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ph_two_point_calibrator verification clean");
    end else begin
      $display("ph_two_point_calibrator verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ptc_pkg.sv
rtl/core/ptc_divider.sv
rtl/core/ph_two_point_calibrator.sv
tb/tb.sv
